// File: rtl/core/rmc_pkg.sv
// Shared types and constants for the rotation matrix composer.
// No dependencies; used by rmc_cordic and rotation_matrix_composer.
`timescale 1ns / 1ps

package rmc_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CORDIC,
    S_ROT,
    S_EMIT_RD,
    S_EMIT_LD
  } rmc_state_t;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } rmc_axis_t;

  localparam logic KIND_RELOAD = 1'b0;

  // Q2.30 constants held as signed values of 34 or 35 bits.
  localparam logic signed [34:0] Q30_PI      = 35'sd3373259426;
  localparam logic signed [34:0] Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [33:0] Q30_GAIN    = 34'sd652032874;

  // atan(2^-i) in Q2.30.
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
    32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
    32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
    32'd127, 32'd63, 32'd31, 32'd15, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
  };

endpackage

// File: rtl/core/rmc_cordic.sv
// Iterative rotation-mode CORDIC giving sine and cosine of a Q2.13 angle.
// Uses rmc_pkg for the arctangent table and Q2.30 constants.
`timescale 1ns / 1ps

module rmc_cordic #(
  parameter int ENTRY_FRAC_BITS = 16,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [15:0]                angle,
  output logic                              done,
  output logic signed [ENTRY_FRAC_BITS+1:0] sin_val,
  output logic signed [ENTRY_FRAC_BITS+1:0] cos_val
);

  localparam int EW = ENTRY_FRAC_BITS + 2;
  localparam int RS = 30 - ENTRY_FRAC_BITS;
  localparam logic signed [35:0] HALF = (RS > 0) ? (36'sd1 <<< (RS - 1)) : 36'sd0;
  localparam logic signed [35:0] ONE  = 36'sd1 <<< ENTRY_FRAC_BITS;
  localparam logic [4:0] LAST = 5'(CORDIC_STEPS - 1);

  logic              busy;
  logic              fin;
  logic              flip;
  logic [4:0]        cnt;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [34:0] z;
  logic signed [34:0] z0;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [34:0] at;

  function automatic logic signed [EW-1:0] narrow(input logic signed [33:0] v);
    logic signed [35:0] t;
    t = 36'(v) + HALF;
    t = t >>> RS;
    if (t > ONE) t = ONE;
    else if (t < -ONE) t = -ONE;
    return t[EW-1:0];
  endfunction

  always_comb begin
    z0 = 35'(angle) <<< 17;
    dx = y >>> cnt;
    dy = x >>> cnt;
    at = 35'(rmc_pkg::ATAN_Q30[cnt]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        x    <= rmc_pkg::Q30_GAIN;
        y    <= '0;
        if (z0 > rmc_pkg::Q30_HALF_PI) begin
          z    <= z0 - rmc_pkg::Q30_PI;
          flip <= 1'b1;
        end else if (z0 < -rmc_pkg::Q30_HALF_PI) begin
          z    <= z0 + rmc_pkg::Q30_PI;
          flip <= 1'b1;
        end else begin
          z    <= z0;
          flip <= 1'b0;
        end
      end else if (busy) begin
        if (!z[34]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
        cnt <= cnt + 5'd1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
      if (fin) begin
        cos_val <= narrow(flip ? -x : x);
        sin_val <= narrow(flip ? -y : y);
      end
    end
  end

endmodule

// File: rtl/core/rotation_matrix_composer.sv
// Rotation matrix composer: holds a 4x4 transform and right-multiplies it
// by elementary rotations. Depends on rmc_pkg and rmc_cordic.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid, in_stall, kind, axis, angle) takes one item
// at a time. A reload item restores the identity; a rotation item computes
// M = M * R about the given axis. Axis three leaves the matrix unchanged.
// Each item produces four result items on the output channel, rows 0 to 3,
// with last_row set on row 3.
// The matrix is kept in a four-row memory (one row per word, registered
// read). A rotation runs the CORDIC for CORDIC_STEPS iterations, then
// visits each row in seven phases with one shared multiplier (four
// products per row) before its first row appears; each row is emitted
// through a read state (S_EMIT_RD) and a load state (S_EMIT_LD).
// A reload or axis-three item goes straight to emission. in_stall is high
// for the whole of an item's work, so items are processed one at a time.
// Reset clears the row valid bits, so every row reads as identity until it
// is written; no clearing pass is needed. When the receiver stalls, the
// output register holds its row and the block waits before the next row.
module rotation_matrix_composer #(
  parameter int ENTRY_FRAC_BITS = 16,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic [1:0]                        axis,
  input  logic signed [15:0]                angle,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        row_index,
  output logic signed [ENTRY_FRAC_BITS+1:0] col0,
  output logic signed [ENTRY_FRAC_BITS+1:0] col1,
  output logic signed [ENTRY_FRAC_BITS+1:0] col2,
  output logic signed [ENTRY_FRAC_BITS+1:0] col3,
  output logic                              last_row
);

  localparam int EW = ENTRY_FRAC_BITS + 2;
  localparam int PW = 2 * EW;
  localparam logic signed [PW+1:0] ONE  = (PW+2)'(1) <<< ENTRY_FRAC_BITS;
  localparam logic signed [PW+1:0] HALF = (PW+2)'(1) <<< (ENTRY_FRAC_BITS - 1);
  localparam logic signed [EW-1:0] E_ONE = EW'(1) <<< ENTRY_FRAC_BITS;
  localparam logic [2:0] PH_LAST = 3'd6;

  rmc_pkg::rmc_state_t state, state_next;

  logic [2:0] ph;
  logic [1:0] row_cnt;
  logic [1:0] ca;
  logic [1:0] cb;
  logic       in_acc;
  logic       cor_start;
  logic       cor_done;
  logic signed [EW-1:0] sn;
  logic signed [EW-1:0] cs;

  // Row memory and its valid bits; an invalid row reads as identity.
  logic [4*EW-1:0] mem [4];
  logic [4*EW-1:0] mem_q;
  logic [3:0]      row_vld;
  logic            rd_vld_q;
  logic [1:0]      rd_row_q;
  logic            rd_en;
  logic            wr_en;
  logic            out_free;
  logic            out_load;
  logic [4*EW-1:0] rd_eff;
  logic [4*EW-1:0] ident;
  logic [4*EW-1:0] wr_data;

  logic signed [EW-1:0] row_q [4];
  logic signed [EW-1:0] a_val;
  logic signed [EW-1:0] b_val;
  logic signed [EW-1:0] op_a;
  logic signed [EW-1:0] op_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] acc;
  logic signed [EW-1:0] na;
  logic signed [EW-1:0] nb;

  function automatic logic signed [EW-1:0] narrow(input logic signed [PW:0] v);
    logic signed [PW+1:0] t;
    t = (PW+2)'(v) + HALF;
    t = t >>> ENTRY_FRAC_BITS;
    if (t > ONE) t = ONE;
    else if (t < -ONE) t = -ONE;
    return t[EW-1:0];
  endfunction

  rmc_cordic #(
    .ENTRY_FRAC_BITS(ENTRY_FRAC_BITS),
    .CORDIC_STEPS   (CORDIC_STEPS)
  ) u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (cor_start),
    .angle  (angle),
    .done   (cor_done),
    .sin_val(sn),
    .cos_val(cs)
  );

  assign in_acc    = in_valid && !in_stall;
  assign cor_start = in_acc && (kind != rmc_pkg::KIND_RELOAD)
                     && (axis != rmc_pkg::AXIS_NONE);
  assign out_free  = !out_valid || !out_stall;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      rmc_pkg::S_IDLE: begin
        if (cor_start) state_next = rmc_pkg::S_CORDIC;
        else if (in_acc) state_next = rmc_pkg::S_EMIT_RD;
      end
      rmc_pkg::S_CORDIC: begin
        if (cor_done) state_next = rmc_pkg::S_ROT;
      end
      rmc_pkg::S_ROT: begin
        if (ph == PH_LAST && row_cnt == 2'd3) state_next = rmc_pkg::S_EMIT_RD;
      end
      rmc_pkg::S_EMIT_RD: state_next = rmc_pkg::S_EMIT_LD;
      rmc_pkg::S_EMIT_LD: begin
        if (out_free) state_next = (row_cnt == 2'd3) ? rmc_pkg::S_IDLE : rmc_pkg::S_EMIT_RD;
      end
      default: state_next = rmc_pkg::S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    out_load = 1'b0;
    unique case (state)
      rmc_pkg::S_IDLE:    in_stall = 1'b0;
      rmc_pkg::S_CORDIC:  ;
      rmc_pkg::S_ROT: begin
        rd_en = (ph == 3'd0);
        wr_en = (ph == PH_LAST);
      end
      rmc_pkg::S_EMIT_RD: rd_en = 1'b1;
      rmc_pkg::S_EMIT_LD: out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      ident[c*EW +: EW] = (2'(c) == rd_row_q) ? E_ONE : '0;
    end
    rd_eff = rd_vld_q ? mem_q : ident;
    a_val  = row_q[ca];
    b_val  = row_q[cb];
    unique case (ph)
      3'd2:    begin op_a = a_val; op_b = cs; end
      3'd3:    begin op_a = b_val; op_b = sn; end
      3'd4:    begin op_a = b_val; op_b = cs; end
      default: begin op_a = a_val; op_b = sn; end
    endcase
    nb = narrow((PW+1)'(acc) - (PW+1)'(prod));
    for (int c = 0; c < 4; c++) begin
      if (2'(c) == ca) wr_data[c*EW +: EW] = na;
      else if (2'(c) == cb) wr_data[c*EW +: EW] = nb;
      else wr_data[c*EW +: EW] = row_q[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q    <= mem[row_cnt];
      rd_vld_q <= row_vld[row_cnt];
      rd_row_q <= row_cnt;
    end
    if (wr_en) begin
      mem[row_cnt] <= wr_data;
    end
  end

  // Rotation datapath: one product per cycle, accumulated into a new pair.
  always_ff @(posedge clk) begin
    if (state == rmc_pkg::S_ROT) begin
      if (ph == 3'd1) begin
        for (int c = 0; c < 4; c++) row_q[c] <= rd_eff[c*EW +: EW];
      end
      prod <= op_a * op_b;
      if (ph == 3'd3 || ph == 3'd5) acc <= prod;
      if (ph == 3'd4) na <= narrow((PW+1)'(acc) + (PW+1)'(prod));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rmc_pkg::S_IDLE;
      ph        <= '0;
      row_cnt   <= '0;
      row_vld   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        if (kind == rmc_pkg::KIND_RELOAD) row_vld <= '0;
        unique case (rmc_pkg::rmc_axis_t'(axis))
          rmc_pkg::AXIS_X:    begin ca <= 2'd1; cb <= 2'd2; end
          rmc_pkg::AXIS_Y:    begin ca <= 2'd2; cb <= 2'd0; end
          rmc_pkg::AXIS_Z:    begin ca <= 2'd0; cb <= 2'd1; end
          rmc_pkg::AXIS_NONE: begin ca <= 2'd0; cb <= 2'd1; end
        endcase
      end
      if (wr_en) row_vld[row_cnt] <= 1'b1;
      if (state == rmc_pkg::S_ROT) begin
        ph <= (ph == PH_LAST) ? 3'd0 : ph + 3'd1;
        if (ph == PH_LAST) row_cnt <= row_cnt + 2'd1;
      end
      if (out_load) begin
        row_cnt   <= row_cnt + 2'd1;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      row_index <= rd_row_q;
      col0      <= rd_eff[0*EW +: EW];
      col1      <= rd_eff[1*EW +: EW];
      col2      <= rd_eff[2*EW +: EW];
      col3      <= rd_eff[3*EW +: EW];
      last_row  <= (rd_row_q == 2'd3);
    end
  end

  // An accepted item always moves the controller out of idle.
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state != rmc_pkg::S_IDLE)
    else $error("accepted item left controller idle");

  // The row counter is back at zero whenever the block is idle.
  a_idle_row: assert property (@(posedge clk) disable iff (rst)
    state == rmc_pkg::S_IDLE |-> row_cnt == 2'd0)
    else $error("row counter not zero in idle");

  // CORDIC results only arrive while the controller waits for them.
  a_cordic_done: assert property (@(posedge clk) disable iff (rst)
    cor_done |-> state == rmc_pkg::S_CORDIC)
    else $error("unexpected CORDIC completion");

  // A row write is always followed by either the next row read or emission.
  a_write_next: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (state == rmc_pkg::S_ROT && ph == 3'd0) || state == rmc_pkg::S_EMIT_RD)
    else $error("row write out of sequence");

endmodule
